// File: hw/rtl/ppta_pkg.sv
// Shared types, constants and codes for the perspective plane texel addresser.
package ppta_pkg;

    localparam int SCREEN_WIDTH_DEF = 320;
    localparam logic [9:0] FOCAL_RESET = 10'd240;
    localparam int ROW_BIAS = 100;
    localparam int COL_BIAS = 161;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROW,
        ST_ROW2,
        ST_CHECK,
        ST_DIV,
        ST_DSTORE,
        ST_SMALL,
        ST_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic       capture;
        logic       load_step;
        logic       row_step;
        logic       row_sel;
        logic       div_start;
        logic       div_step;
        logic [1:0] div_sel;
        logic       div_store;
        logic       small_store;
        logic       pixel;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic c_big;
        logic div_last;
        logic [2:0] load_last;
    } dp_stat_t;

endpackage

// File: hw/rtl/ppta_ctrl.sv
// Command sequencer of the texel addresser.
module ppta_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_command,
    output logic              m_valid,
    input  logic              m_ready,
    output ppta_pkg::dp_cmd_t cmd,
    input  ppta_pkg::dp_stat_t stat
);

    ppta_pkg::state_t state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic m_valid_reg, m_valid_next;

    // next state
    always_comb begin
        state_next = state_reg;
        sel_next = sel_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ppta_pkg::ST_IDLE: begin
                sel_next = 2'd0;
                if (s_valid) begin
                    case (ppta_pkg::cmd_t'(s_command))
                        ppta_pkg::CMD_LOAD:  state_next = ppta_pkg::ST_LOAD;
                        ppta_pkg::CMD_START: state_next = ppta_pkg::ST_ROW;
                        ppta_pkg::CMD_STEP: begin
                            if (!m_valid_reg || m_ready) begin
                                m_valid_next = 1'b1;
                            end
                        end
                        default: state_next = ppta_pkg::ST_IDLE;
                    endcase
                end
            end
            ppta_pkg::ST_LOAD: begin
                if (stat.load_last == 3'd4) state_next = ppta_pkg::ST_IDLE;
            end
            ppta_pkg::ST_ROW: state_next = ppta_pkg::ST_ROW2;
            ppta_pkg::ST_ROW2: state_next = ppta_pkg::ST_CHECK;
            ppta_pkg::ST_CHECK: begin
                state_next = stat.c_big ? ppta_pkg::ST_DIV : ppta_pkg::ST_SMALL;
            end
            ppta_pkg::ST_DIV: begin
                if (stat.div_last) state_next = ppta_pkg::ST_DSTORE;
            end
            ppta_pkg::ST_DSTORE: begin
                sel_next = sel_reg + 2'd1;
                state_next = (sel_reg == 2'd3) ? ppta_pkg::ST_IDLE : ppta_pkg::ST_CHECK;
            end
            ppta_pkg::ST_SMALL: state_next = ppta_pkg::ST_IDLE;
            default: state_next = ppta_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        cmd.div_sel = sel_reg;
        case (state_reg)
            ppta_pkg::ST_IDLE: begin
                s_ready = (ppta_pkg::cmd_t'(s_command) != ppta_pkg::CMD_STEP)
                          || !m_valid_reg || m_ready;
                cmd.capture = s_valid && s_ready;
                cmd.pixel = s_valid && s_ready
                            && (ppta_pkg::cmd_t'(s_command) == ppta_pkg::CMD_STEP);
            end
            ppta_pkg::ST_LOAD:   cmd.load_step = 1'b1;
            ppta_pkg::ST_ROW:    cmd.row_step = 1'b1;
            ppta_pkg::ST_ROW2: begin
                cmd.row_step = 1'b1;
                cmd.row_sel = 1'b1;
            end
            ppta_pkg::ST_CHECK:  cmd.div_start = stat.c_big;
            ppta_pkg::ST_DIV:    cmd.div_step = 1'b1;
            ppta_pkg::ST_DSTORE: begin
                cmd.div_store = 1'b1;
                cmd.div_sel = sel_reg;
            end
            ppta_pkg::ST_SMALL:  cmd.small_store = 1'b1;
            default: cmd = '0;
        endcase
    end

    // hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ppta_pkg::ST_IDLE;
            sel_reg <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: hw/rtl/ppta_datapath.sv
// Plane constants, row projection, divider and pixel stepping.
module ppta_datapath #(
    parameter int SCREEN_WIDTH = ppta_pkg::SCREEN_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ppta_pkg::dp_cmd_t  cmd,
    output ppta_pkg::dp_stat_t stat,
    input  logic [9:0]         focal,
    input  logic signed [23:0] origin_x, origin_y, origin_z,
    input  logic signed [23:0] axis_u_x, axis_u_y, axis_u_z,
    input  logic signed [23:0] axis_v_x, axis_v_y, axis_v_z,
    input  logic [7:0]         screen_row,
    output logic [15:0]        texel_index,
    output logic               last_in_row
);

    localparam int CW = $clog2(SCREEN_WIDTH);

    // captured operands
    logic signed [23:0] in_reg [9];
    logic [7:0] row_reg;
    logic [9:0] f_reg;
    // constants: Cx Cy Cz Ax Ay Az Bx By Bz
    logic signed [63:0] pc_reg [9];
    logic [2:0] lcnt_reg;
    logic signed [63:0] sa_reg, sb_reg, sc_reg;
    logic [31:0] u_reg, v_reg, du_reg, dv_reg;
    logic [CW-1:0] col_reg;
    logic [15:0] tex_reg;
    logic last_reg;

    // load plane: two products per cycle per cross term, then focal scaling
    logic signed [48:0] p0, p1, diff;
    logic signed [23:0] m0a, m0b, m1a, m1b;
    logic signed [48:0] cross_reg [9];
    always_comb begin
        m0a = in_reg[0]; m0b = in_reg[0]; m1a = in_reg[0]; m1b = in_reg[0];
        case (lcnt_reg)
            3'd0: begin m0a = in_reg[4]; m0b = in_reg[8]; m1a = in_reg[7]; m1b = in_reg[5]; end
            3'd1: begin m0a = in_reg[6]; m0b = in_reg[5]; m1a = in_reg[3]; m1b = in_reg[8]; end
            3'd2: begin m0a = in_reg[0]; m0b = in_reg[8]; m1a = in_reg[6]; m1b = in_reg[2]; end
            3'd3: begin m0a = in_reg[7]; m0b = in_reg[2]; m1a = in_reg[1]; m1b = in_reg[8]; end
            default: begin m0a = in_reg[1]; m0b = in_reg[5]; m1a = in_reg[4]; m1b = in_reg[2]; end
        endcase
        p0 = 49'(m0a * m0b);
        p1 = 49'(m1a * m1b);
        diff = p0 - p1;
    end
    // remaining cross terms: Az, Cz and Bz before scaling, and By
    logic signed [48:0] q0, q1, q2, q3;
    always_comb begin
        q0 = 49'(in_reg[6] * in_reg[1]) - 49'(in_reg[0] * in_reg[7]);
        q1 = 49'(in_reg[3] * in_reg[7]) - 49'(in_reg[6] * in_reg[4]);
        q2 = 49'(in_reg[3] * in_reg[2]) - 49'(in_reg[0] * in_reg[5]);
        q3 = 49'(in_reg[0] * in_reg[4]) - 49'(in_reg[3] * in_reg[1]);
    end
    logic signed [58:0] fz;
    logic signed [48:0] fsel;
    always_comb begin
        case (lcnt_reg)
            3'd2: fsel = cross_reg[2];
            3'd3: fsel = cross_reg[5];
            default: fsel = cross_reg[8];
        endcase
        fz = fsel * $signed({1'b0, f_reg});
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg[0] <= origin_x; in_reg[1] <= origin_y; in_reg[2] <= origin_z;
            in_reg[3] <= axis_u_x; in_reg[4] <= axis_u_y; in_reg[5] <= axis_u_z;
            in_reg[6] <= axis_v_x; in_reg[7] <= axis_v_y; in_reg[8] <= axis_v_z;
            row_reg <= screen_row;
            f_reg <= focal;
        end
    end

    // sequence the load: x and y constants from the shared pair (By from its own pair), z terms scaled later
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcnt_reg <= 3'd0;
            for (int i = 0; i < 9; i++) pc_reg[i] <= '0;
        end else if (cmd.load_step) begin
            lcnt_reg <= lcnt_reg + 3'd1;
            case (lcnt_reg)
                3'd0: begin
                    pc_reg[0] <= 64'(diff);
                    cross_reg[2] <= q1;
                end
                3'd1: begin
                    pc_reg[1] <= 64'(diff);
                    cross_reg[5] <= q0;
                    cross_reg[8] <= q3;
                end
                3'd2: begin
                    pc_reg[2] <= 64'(fz);
                    pc_reg[4] <= 64'(diff);
                end
                3'd3: begin
                    pc_reg[5] <= 64'(fz);
                    pc_reg[3] <= 64'(diff);
                end
                default: begin
                    pc_reg[8] <= 64'(fz);
                    pc_reg[7] <= 64'(q2);
                    pc_reg[6] <= 64'(diff);
                end
            endcase
        end else begin
            lcnt_reg <= 3'd0;
        end
    end

    // row sums: z + y*dr first, then x*-161
    logic signed [8:0] dr;
    logic signed [63:0] ra, rb, rc;
    always_comb begin
        dr = $signed({1'b0, row_reg}) - 9'sd100;
        if (!cmd.row_sel) begin
            ra = pc_reg[5] + pc_reg[4] * 64'(dr);
            rb = pc_reg[8] + pc_reg[7] * 64'(dr);
            rc = pc_reg[2] + pc_reg[1] * 64'(dr);
        end else begin
            ra = sa_reg - pc_reg[3] * 64'sd161;
            rb = sb_reg - pc_reg[6] * 64'sd161;
            rc = sc_reg - pc_reg[0] * 64'sd161;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.row_step) begin
            sa_reg <= ra;
            sb_reg <= rb;
            sc_reg <= rc;
        end
    end

    logic [63:0] cmag;
    assign cmag = sc_reg[63] ? 64'(-sc_reg) : 64'(sc_reg);
    assign stat.c_big = cmag > 64'h1_0000_0000;

    // restoring divider: one quotient bit per cycle, 88 dividend bits
    logic signed [63:0] num;
    always_comb begin
        case (cmd.div_sel)
            2'd0: num = sa_reg;
            2'd1: num = sb_reg;
            2'd2: num = pc_reg[3];
            default: num = pc_reg[6];
        endcase
    end
    logic [63:0] nmag;
    assign nmag = num[63] ? 64'(-num) : 64'(num);
    logic [87:0] dvd_reg;
    logic [64:0] rem_reg;
    logic [6:0] dcnt_reg;
    logic [64:0] rsh, rsub;
    assign rsh = {rem_reg[63:0], dvd_reg[87]};
    assign rsub = rsh - {1'b0, cmag};
    assign stat.div_last = dcnt_reg == 7'd87;
    assign stat.load_last = lcnt_reg;
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dvd_reg <= {nmag[63:0], 24'd0};
            rem_reg <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg + 7'd1;
            if (!rsub[64]) begin
                rem_reg <= rsub;
                dvd_reg <= {dvd_reg[86:0], 1'b1};
            end else begin
                rem_reg <= rsh;
                dvd_reg <= {dvd_reg[86:0], 1'b0};
            end
        end
    end

    // saturate sign and magnitude into 32 bits
    function automatic logic [31:0] sat32(input logic neg, input logic [87:0] mag);
        logic [31:0] r;
        if (neg) begin
            r = (mag >= 88'h8000_0000) ? 32'h8000_0000 : 32'(-mag[31:0]);
        end else begin
            r = (mag > 88'h7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
        end
        return r;
    endfunction

    logic dneg;
    logic [31:0] dres;
    assign dneg = (num[63] != sc_reg[63]) && (dvd_reg != '0);
    assign dres = sat32(dneg, dvd_reg);

    logic [31:0] sm_a, sm_b, sm_du, sm_dv;
    function automatic logic [31:0] small_scale(input logic signed [63:0] x);
        logic [63:0] m;
        m = (x[63] ? 64'(-x) : 64'(x)) >> 8;
        return sat32(x[63] && (m != '0), 88'(m));
    endfunction
    assign sm_a = small_scale(sa_reg);
    assign sm_b = small_scale(sb_reg);
    assign sm_du = small_scale(pc_reg[3]);
    assign sm_dv = small_scale(pc_reg[6]);

    // coordinate state and pixel output
    logic plast;
    assign plast = col_reg >= CW'(SCREEN_WIDTH - 1);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_reg <= '0; v_reg <= '0; du_reg <= '0; dv_reg <= '0;
            col_reg <= '0;
        end else if (cmd.small_store) begin
            u_reg <= sm_a; v_reg <= sm_b; du_reg <= sm_du; dv_reg <= sm_dv;
            col_reg <= '0;
        end else if (cmd.div_store) begin
            case (cmd.div_sel)
                2'd0: u_reg <= dres;
                2'd1: v_reg <= dres;
                2'd2: du_reg <= dres;
                default: begin
                    dv_reg <= dres;
                    col_reg <= '0;
                end
            endcase
        end else if (cmd.pixel) begin
            tex_reg <= {v_reg[23:16], u_reg[23:16]};
            last_reg <= plast;
            u_reg <= u_reg + du_reg;
            v_reg <= v_reg + dv_reg;
            col_reg <= plast ? '0 : col_reg + CW'(1);
        end
    end

    assign texel_index = tex_reg;
    assign last_in_row = last_reg;

endmodule

// File: hw/rtl/perspective_plane_texel_addresser.sv
// Top level of the perspective plane texel addresser.
//   channel | direction | handshake
//   s_*     | in        | s_valid / s_ready, command and plane fields
//   m_*     | out       | m_valid / m_ready, texel_index and last_in_row
//   apb     | in        | psel/penable/pwrite, focal_distance at 0x0
// Step pixel is handled in idle; load plane captures, then uses the shared
// multiply pair. Start row sums the row; if |c| exceeds 2^32, each of the
// four values gets a check, a division and a store; else all are scaled.
// Reset is synchronous, active low.
// Stalled results hold in the output register; steps stall then or when busy.
module perspective_plane_texel_addresser #(
    parameter int SCREEN_WIDTH = ppta_pkg::SCREEN_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic signed [23:0] s_origin_x,
    input  logic signed [23:0] s_origin_y,
    input  logic signed [23:0] s_origin_z,
    input  logic signed [23:0] s_axis_u_x,
    input  logic signed [23:0] s_axis_u_y,
    input  logic signed [23:0] s_axis_u_z,
    input  logic signed [23:0] s_axis_v_x,
    input  logic signed [23:0] s_axis_v_y,
    input  logic signed [23:0] s_axis_v_z,
    input  logic [7:0]         s_screen_row,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_texel_index,
    output logic               m_last_in_row,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    ppta_pkg::dp_cmd_t  cmd;
    ppta_pkg::dp_stat_t stat;
    logic [9:0] focal_reg;

    // hold the focal distance register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_reg <= ppta_pkg::FOCAL_RESET;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            focal_reg <= pwdata[9:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {22'd0, focal_reg} : 32'd0;

    ppta_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_command,
        .m_valid, .m_ready, .cmd, .stat
    );

    ppta_datapath #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_dp (
        .aclk, .aresetn, .cmd, .stat, .focal(focal_reg),
        .origin_x(s_origin_x), .origin_y(s_origin_y), .origin_z(s_origin_z),
        .axis_u_x(s_axis_u_x), .axis_u_y(s_axis_u_y), .axis_u_z(s_axis_u_z),
        .axis_v_x(s_axis_v_x), .axis_v_y(s_axis_v_y), .axis_v_z(s_axis_v_z),
        .screen_row(s_screen_row),
        .texel_index(m_texel_index), .last_in_row(m_last_in_row)
    );

endmodule

// File: test/tb.sv
// Self-checking testbench for the perspective plane texel addresser.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH = 320;
    localparam int DRAIN_CYCLES = 400;
    localparam int STALL_LIMIT = 20000;
    localparam int K_CX = 0, K_CY = 1, K_CZ = 2, K_AX = 3, K_AY = 4, K_AZ = 5;
    localparam int K_BX = 6, K_BY = 7, K_BZ = 8;
    localparam logic [1:0] ADDR_FOCAL = 2'd0;

    typedef struct {
        ppta_pkg::cmd_t     cmd;
        logic signed [23:0] vec [9];
        logic [7:0]         row;
    } plane_cmd_t;

    typedef struct {
        logic [15:0] texel;
        logic        last;
    } texel_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_command = '0;
    logic signed [23:0] s_vec [9] = '{default: '0};
    logic [7:0] s_screen_row = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [15:0] m_texel_index;
    logic m_last_in_row;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // predictor state
    longint plane_k [9];
    logic [31:0] u_acc, v_acc, u_inc, v_inc;
    int col;
    logic [9:0] focal;
    texel_t texel_q [$];
    int mismatches = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    bit no_idle = 1'b0;

    always #1 aclk = ~aclk;

    perspective_plane_texel_addresser i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_origin_x(s_vec[0]), .s_origin_y(s_vec[1]), .s_origin_z(s_vec[2]),
        .s_axis_u_x(s_vec[3]), .s_axis_u_y(s_vec[4]), .s_axis_u_z(s_vec[5]),
        .s_axis_v_x(s_vec[6]), .s_axis_v_y(s_vec[7]), .s_axis_v_z(s_vec[8]),
        .s_screen_row(s_screen_row),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_texel_index(m_texel_index), .m_last_in_row(m_last_in_row),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    function automatic logic [63:0] abs64(longint x);
        return x < 0 ? -x : x;
    endfunction

    // clamp a sign and magnitude to the signed 32-bit range
    function automatic logic [31:0] clamp32(bit neg, logic [127:0] m);
        if (neg)
            return (m >= 128'h8000_0000) ? 32'h8000_0000 : -m[31:0];
        return (m > 128'h7fff_ffff) ? 32'h7fff_ffff : m[31:0];
    endfunction

    // num * 2^24 / den, truncated toward zero
    function automatic logic [31:0] project_div(longint num, longint den);
        logic [127:0] n, d, q;
        n = {64'd0, abs64(num)} << 24;
        d = {64'd0, abs64(den)};
        q = n / d;
        return clamp32(((num < 0) != (den < 0)) && q != 0, q);
    endfunction

    function automatic logic [31:0] project_small(longint num);
        logic [127:0] m;
        m = {64'd0, abs64(num) >> 8};
        return clamp32(num < 0 && m != 0, m);
    endfunction

    // advance the predictor by one accepted command
    function automatic void predict_texel(plane_cmd_t c);
        longint bx, by, bz, ux, uy, uz, vx, vy, vz, fl, dr, a, b, cz;
        texel_t t;
        bit last;
        bx = c.vec[0]; by = c.vec[1]; bz = c.vec[2];
        ux = c.vec[3]; uy = c.vec[4]; uz = c.vec[5];
        vx = c.vec[6]; vy = c.vec[7]; vz = c.vec[8];
        fl = focal;
        case (c.cmd)
            ppta_pkg::CMD_LOAD: begin
                plane_k[K_CX] = uy * vz - vy * uz;
                plane_k[K_CY] = vx * uz - ux * vz;
                plane_k[K_CZ] = (ux * vy - vx * uy) * fl;
                plane_k[K_AX] = vy * bz - by * vz;
                plane_k[K_AY] = bx * vz - vx * bz;
                plane_k[K_AZ] = (vx * by - bx * vy) * fl;
                plane_k[K_BX] = by * uz - uy * bz;
                plane_k[K_BY] = ux * bz - bx * uz;
                plane_k[K_BZ] = (bx * uy - ux * by) * fl;
            end
            ppta_pkg::CMD_START: begin
                dr = longint'(c.row) - ppta_pkg::ROW_BIAS;
                a = plane_k[K_AZ] + plane_k[K_AY] * dr - plane_k[K_AX] * ppta_pkg::COL_BIAS;
                b = plane_k[K_BZ] + plane_k[K_BY] * dr - plane_k[K_BX] * ppta_pkg::COL_BIAS;
                cz = plane_k[K_CZ] + plane_k[K_CY] * dr - plane_k[K_CX] * ppta_pkg::COL_BIAS;
                if (abs64(cz) > 64'h1_0000_0000) begin
                    u_acc = project_div(a, cz);
                    v_acc = project_div(b, cz);
                    u_inc = project_div(plane_k[K_AX], cz);
                    v_inc = project_div(plane_k[K_BX], cz);
                end else begin
                    u_acc = project_small(a);
                    v_acc = project_small(b);
                    u_inc = project_small(plane_k[K_AX]);
                    v_inc = project_small(plane_k[K_BX]);
                end
                col = 0;
            end
            ppta_pkg::CMD_STEP: begin
                last = col >= WIDTH - 1;
                t.texel = {v_acc[23:16], u_acc[23:16]};
                t.last = last;
                texel_q.push_back(t);
                u_acc += u_inc;
                v_acc += v_inc;
                col = last ? 0 : col + 1;
            end
            default: ;
        endcase
    endfunction

    // drive one command and hold it until the transfer
    task automatic send_cmd(plane_cmd_t c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= c.cmd;
        for (int i = 0; i < 9; i++) s_vec[i] <= c.vec[i];
        s_screen_row <= c.row;
        do @(posedge aclk); while (!s_ready);
        predict_texel(c);
        items_sent++;
    endtask

    function automatic logic signed [23:0] rand_coord();
        logic signed [23:0] r;
        r = 24'($urandom);
        return r >>> $urandom_range(0, 23);
    endfunction

    function automatic plane_cmd_t make_cmd(ppta_pkg::cmd_t op);
        plane_cmd_t c;
        c.cmd = op;
        for (int i = 0; i < 9; i++) c.vec[i] = rand_coord();
        c.row = 8'($urandom);
        return c;
    endfunction

    task automatic send_op(ppta_pkg::cmd_t op);
        send_cmd(make_cmd(op));
    endtask

    task automatic send_start(logic [7:0] row);
        plane_cmd_t c;
        c = make_cmd(ppta_pkg::CMD_START);
        c.row = row;
        send_cmd(c);
    endtask

    task automatic send_load(logic signed [23:0] v [9]);
        plane_cmd_t c;
        c = make_cmd(ppta_pkg::CMD_LOAD);
        c.vec = v;
        send_cmd(c);
    endtask

    task automatic send_steps(int n);
        repeat (n) send_op(ppta_pkg::CMD_STEP);
    endtask

    // hold the sender until every expected texel has come, then let a row finish
    task automatic drain();
        s_valid <= 1'b0;
        while (texel_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_focal(logic [9:0] value);
        drain();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_FOCAL; pwdata <= {22'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        focal = value;
    endtask

    task automatic test_directed();
        logic signed [23:0] v [9];
        // pixels from the reset state, and the unused command
        send_steps(2);
        send_op(ppta_pkg::CMD_NONE);
        // field extremes: parallel vectors give zero constants
        v = '{default: 24'sh7fffff};
        send_load(v);
        send_start(8'd0);
        send_steps(1);
        v = '{default: 24'sh800000};
        send_load(v);
        send_start(8'd255);
        send_steps(1);
        // divider path, then a row where c is exactly zero
        v = '{24'sh7fffff, 24'sh800000, 24'sh7fffff, 24'sh010000, 24'sh0, 24'sh0,
              24'sh0, 24'sh0, 24'sh010000};
        send_load(v);
        send_start(8'd0);
        send_steps(3);
        send_start(8'd255);
        send_steps(2);
        send_start(8'd100);
        send_steps(2);
        // scale path with small constants
        v = '{24'sh000500, 24'shfffa00, 24'sh000300, 24'sh000100, 24'sh0, 24'sh0,
              24'sh0, 24'sh000100, 24'sh0};
        send_load(v);
        send_start(8'd105);
        send_steps(3);
    endtask

    task automatic test_row_wrap();
        send_op(ppta_pkg::CMD_LOAD);
        send_start(8'($urandom));
        no_idle = 1'b1;
        send_steps(2 * WIDTH + 5);
        no_idle = 1'b0;
    endtask

    task automatic test_focal();
        logic [9:0] setting [4] = '{10'd1, 10'd1023, 10'd0, ppta_pkg::FOCAL_RESET};
        setting[2] = 10'($urandom_range(2, 1022));
        foreach (setting[i]) begin
            write_focal(setting[i]);
            send_op(ppta_pkg::CMD_LOAD);
            send_start(8'($urandom));
            send_steps($urandom_range(3, 12));
        end
    endtask

    task automatic test_random();
        while (items_sent < 1300) begin
            send_op(ppta_pkg::CMD_LOAD);
            repeat ($urandom_range(1, 4)) begin
                no_idle = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 9) == 0) drain();
                send_start(8'($urandom));
                send_steps(($urandom_range(0, 15) == 0) ? 325 : $urandom_range(1, 30));
                if ($urandom_range(0, 9) == 0) send_op(ppta_pkg::CMD_NONE);
            end
        end
        no_idle = 1'b0;
    endtask

    // result side backpressure
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        texel_t t;
        if (aresetn && m_valid && m_ready) begin
            if (texel_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected texel %h last %b", m_texel_index, m_last_in_row);
                mismatches++;
            end else begin
                t = texel_q.pop_front();
                if (t.texel !== m_texel_index || t.last !== m_last_in_row) begin
                    if (mismatches < 10)
                        $display("texel exp %h last %b, got %h last %b",
                                 t.texel, t.last, m_texel_index, m_last_in_row);
                    mismatches++;
                end
            end
        end
    end

    // end the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        plane_k = '{default: 0};
        u_acc = '0; v_acc = '0; u_inc = '0; v_inc = '0;
        col = 0;
        focal = ppta_pkg::FOCAL_RESET;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_row_wrap();
        test_focal();
        test_random();
        drain();
        if (mismatches == 0 && texel_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
